// ----- hdl/rhsv_pkg.sv -----
// Types, constants and register codes shared by the RGB565 HSV red classifier.
package rhsv_pkg;

	localparam int CH_W          = 11;
	localparam int DEN_W         = 14;
	localparam int CFG_W         = 16;
	localparam int HUE_W         = 16;
	localparam int SAT_W         = 17;
	localparam int CFG_IDX_W     = 2;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [CH_W-1:0] SCALE_RB = CH_W'(63);
	localparam logic [CH_W-1:0] SCALE_G  = CH_W'(31);

	localparam logic [CFG_W-1:0] SAT_THR_RST = CFG_W'(32768);
	localparam logic [CFG_W-1:0] HUE_LO_RST  = CFG_W'(3277);
	localparam logic [CFG_W-1:0] HUE_HI_RST  = CFG_W'(58982);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAT_THR = 2'd0,
		CFG_HUE_LO  = 2'd1,
		CFG_HUE_HI  = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MAX_RED   = 2'd0,
		MAX_GREEN = 2'd1,
		MAX_BLUE  = 2'd2
	} max_sel_t;

	typedef struct packed {
		logic [4:0] red;
		logic [5:0] green;
		logic [4:0] blue;
	} pix_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [SAT_W-1:0] saturation;
		logic [CH_W-1:0]  brightness;
		logic             present;
	} result_t;

	typedef struct packed {
		logic [DEN_W-1:0] sat_num;
		logic [DEN_W-1:0] sat_den;
		logic [DEN_W-1:0] hue_num;
		logic [DEN_W-1:0] hue_den;
		logic [CH_W-1:0]  brightness;
	} div_job_t;

	typedef struct packed {
		logic [CFG_W-1:0] sat;
		logic [CFG_W-1:0] hue_lo;
		logic [CFG_W-1:0] hue_hi;
	} thr_t;

endpackage

// ----- hdl/rhsv_front.sv -----
// Front stages: channel scaling, max/min search, hue numerator and divisors.
module rhsv_front import rhsv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pix_valid,
	output logic     pix_ready,
	input  pix_t     pix,
	output logic     job_valid,
	input  logic     job_ready,
	output div_job_t job
);

	logic            valid_s1, valid_s2;
	logic            rdy_s1, rdy_s2;
	logic [CH_W-1:0] r_sc, g_sc, b_sc, mx_c, mn_c;
	max_sel_t        sel_c;
	logic [CH_W-1:0] r_s1, g_s1, b_s1, mx_s1, mn_s1;
	max_sel_t        sel_s1;
	logic [CH_W-1:0] delta;
	logic [DEN_W-1:0] delta_w, six_w, rw, gw, bw, num_c;
	div_job_t        job_c, job_s2;

	assign rdy_s2    = !valid_s2 || job_ready;
	assign rdy_s1    = !valid_s1 || rdy_s2;
	assign pix_ready = rdy_s1;
	assign job_valid = valid_s2;
	assign job       = job_s2;

	always_comb begin
		r_sc  = CH_W'(pix.red) * SCALE_RB;
		g_sc  = CH_W'(pix.green) * SCALE_G;
		b_sc  = CH_W'(pix.blue) * SCALE_RB;
		mx_c  = r_sc;
		sel_c = MAX_RED;
		if (g_sc > mx_c) begin
			mx_c  = g_sc;
			sel_c = MAX_GREEN;
		end
		if (b_sc > mx_c) begin
			mx_c  = b_sc;
			sel_c = MAX_BLUE;
		end
		mn_c = r_sc;
		if (g_sc < mn_c) begin
			mn_c = g_sc;
		end
		if (b_sc < mn_c) begin
			mn_c = b_sc;
		end
	end

	always_comb begin
		delta   = mx_s1 - mn_s1;
		delta_w = DEN_W'(delta);
		six_w   = (delta_w << 2) + (delta_w << 1);
		rw      = DEN_W'(r_s1);
		gw      = DEN_W'(g_s1);
		bw      = DEN_W'(b_s1);
		unique case (sel_s1)
			MAX_RED: begin
				if (g_s1 >= b_s1) begin
					num_c = gw - bw;
				end else begin
					num_c = six_w + gw - bw;
				end
			end
			MAX_GREEN: num_c = (delta_w << 1) + bw - rw;
			MAX_BLUE:  num_c = (delta_w << 2) + rw - gw;
			default:   num_c = '0;
		endcase
		job_c.sat_num    = delta_w;
		job_c.sat_den    = (delta == '0) ? DEN_W'(1) : DEN_W'(mx_s1);
		job_c.hue_num    = num_c;
		job_c.hue_den    = (delta == '0) ? DEN_W'(1) : six_w;
		job_c.brightness = mx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= pix_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && pix_valid) begin
			r_s1   <= r_sc;
			g_s1   <= g_sc;
			b_s1   <= b_sc;
			mx_s1  <= mx_c;
			mn_s1  <= mn_c;
			sel_s1 <= sel_c;
		end
		if (rdy_s2 && valid_s1) begin
			job_s2 <= job_c;
		end
	end

endmodule

// ----- hdl/rhsv_div.sv -----
// Two-lane restoring fraction divider, one quotient bit per pipeline stage.
module rhsv_div import rhsv_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	output logic                 job_ready,
	input  div_job_t             job,
	output logic                 quo_valid,
	input  logic                 quo_ready,
	output logic [FRAC_BITS:0]   sat_quo,
	output logic [FRAC_BITS:0]   hue_quo,
	output logic [CH_W-1:0]      brightness
);

	localparam int NST = FRAC_BITS + 1;
	localparam int QW  = FRAC_BITS + 1;

	logic             valid_s [NST];
	logic             rdy     [NST];
	logic [DEN_W-1:0] srem_s  [NST];
	logic [DEN_W-1:0] sden_s  [NST];
	logic [DEN_W-1:0] hrem_s  [NST];
	logic [DEN_W-1:0] hden_s  [NST];
	logic [QW-1:0]    squo_s  [NST];
	logic [QW-1:0]    hquo_s  [NST];
	logic [CH_W-1:0]  bri_s   [NST];

	function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
		input logic [DEN_W-1:0] den);
		logic [DEN_W:0] t;
		logic [DEN_W:0] d;
		t = {rem, 1'b0};
		d = {1'b0, den};
		if (t >= d) begin
			div_step = {1'b1, DEN_W'(t - d)};
		end else begin
			div_step = {1'b0, DEN_W'(t)};
		end
	endfunction

	assign job_ready  = rdy[0];
	assign quo_valid  = valid_s[NST-1];
	assign sat_quo    = squo_s[NST-1];
	assign hue_quo    = hquo_s[NST-1];
	assign brightness = bri_s[NST-1];

	for (genvar k = 0; k < NST; k++) begin : g_stage
		logic pv;

		if (k == NST - 1) begin : g_last
			assign rdy[k] = !valid_s[k] || quo_ready;
		end else begin : g_mid
			assign rdy[k] = !valid_s[k] || rdy[k+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				valid_s[k] <= pv;
			end
		end

		if (k == 0) begin : g_first
			logic sq, hq;

			assign pv = job_valid;
			assign sq = job.sat_num >= job.sat_den;
			assign hq = job.hue_num >= job.hue_den;

			always_ff @(posedge clk) begin
				if (rdy[k] && pv) begin
					srem_s[k] <= sq ? job.sat_num - job.sat_den : job.sat_num;
					hrem_s[k] <= hq ? job.hue_num - job.hue_den : job.hue_num;
					sden_s[k] <= job.sat_den;
					hden_s[k] <= job.hue_den;
					squo_s[k] <= QW'(sq);
					hquo_s[k] <= QW'(hq);
					bri_s[k]  <= job.brightness;
				end
			end
		end else begin : g_step
			logic [DEN_W:0] sstep, hstep;

			assign pv    = valid_s[k-1];
			assign sstep = div_step(srem_s[k-1], sden_s[k-1]);
			assign hstep = div_step(hrem_s[k-1], hden_s[k-1]);

			always_ff @(posedge clk) begin
				if (rdy[k] && pv) begin
					srem_s[k] <= sstep[DEN_W-1:0];
					hrem_s[k] <= hstep[DEN_W-1:0];
					sden_s[k] <= sden_s[k-1];
					hden_s[k] <= hden_s[k-1];
					squo_s[k] <= {squo_s[k-1][QW-2:0], sstep[DEN_W]};
					hquo_s[k] <= {hquo_s[k-1][QW-2:0], hstep[DEN_W]};
					bri_s[k]  <= bri_s[k-1];
				end
			end
		end
	end

`ifndef SYNTH
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[NST-1] |-> (srem_s[NST-1] < sden_s[NST-1]) &&
			(hrem_s[NST-1] < hden_s[NST-1]))
		else $error("divider remainder not below divisor");

	a_hue_no_int: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[0] |-> !hquo_s[0][0])
		else $error("hue quotient has an integer part");

	a_sat_max_one: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[NST-1] |-> !(squo_s[NST-1][QW-1] && (|squo_s[NST-1][QW-2:0])))
		else $error("saturation quotient above one");
`endif

endmodule

// ----- hdl/rhsv_out.sv -----
// Output stage: result formatting, threshold test and result register.
module rhsv_out import rhsv_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               quo_valid,
	output logic               quo_ready,
	input  logic [FRAC_BITS:0] sat_quo,
	input  logic [FRAC_BITS:0] hue_quo,
	input  logic [CH_W-1:0]    brightness,
	input  thr_t               thr,
	output logic               res_valid,
	input  logic               res_ready,
	output result_t            res
);

	logic    valid_q;
	result_t res_c, res_q;

	assign quo_ready = !valid_q || res_ready;
	assign res_valid = valid_q;
	assign res       = res_q;

	always_comb begin
		res_c.hue        = HUE_W'(hue_quo);
		res_c.saturation = SAT_W'(sat_quo);
		res_c.brightness = brightness;
		res_c.present    = (res_c.saturation > SAT_W'(thr.sat)) &&
			((res_c.hue < thr.hue_lo) || (res_c.hue > thr.hue_hi));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (quo_ready) begin
			valid_q <= quo_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (quo_ready && quo_valid) begin
			res_q <= res_c;
		end
	end

endmodule

// ----- hdl/rgb565_hsv_red_classifier_unit.sv -----
// Top level of the RGB565 to HSV converter with red presence flag.
//
//   port group   dir  handshake            payload
//   pix          in   pix_valid/pix_ready  pix_t: red, green, blue
//   res          out  res_valid/res_ready  result_t: hue, saturation, brightness, present
//   cfg          in   cfg_wen              cfg_idx, cfg_wdata (thresholds)
//
// One pixel accepted per clock unless back-pressure from res_ready stalls the pipeline.
// The divider makes one quotient bit per stage over FRAC_BITS + 1 stages.
// Reset clears all valid bits and loads the default thresholds.
// Each stage holds under stall and takes a new item as soon as its successor frees.
module rgb565_hsv_red_classifier_unit import rhsv_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	output logic                 pix_ready,
	input  pix_t                 pix,
	output logic                 res_valid,
	input  logic                 res_ready,
	output result_t              res,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	thr_t               thr_q;
	logic               job_valid, job_ready;
	div_job_t           job;
	logic               quo_valid, quo_ready;
	logic [FRAC_BITS:0] sat_quo, hue_quo;
	logic [CH_W-1:0]    bri;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.sat    <= SAT_THR_RST;
			thr_q.hue_lo <= HUE_LO_RST;
			thr_q.hue_hi <= HUE_HI_RST;
		end else if (cfg_wen) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_SAT_THR: thr_q.sat    <= cfg_wdata;
				CFG_HUE_LO:  thr_q.hue_lo <= cfg_wdata;
				CFG_HUE_HI:  thr_q.hue_hi <= cfg_wdata;
				default: ;
			endcase
		end
	end

	rhsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	rhsv_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job_ready  (job_ready),
		.job        (job),
		.quo_valid  (quo_valid),
		.quo_ready  (quo_ready),
		.sat_quo    (sat_quo),
		.hue_quo    (hue_quo),
		.brightness (bri)
	);

	rhsv_out #(
		.FRAC_BITS (FRAC_BITS)
	) u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.quo_valid  (quo_valid),
		.quo_ready  (quo_ready),
		.sat_quo    (sat_quo),
		.hue_quo    (hue_quo),
		.brightness (bri),
		.thr        (thr_q),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

endmodule
